/* rtl/wis_pkg.sv */
// ----------------------------------------------------------------------------
// wis_pkg
// Shared types and constants for the weighted index selector.
// ----------------------------------------------------------------------------
package wis_pkg;

  // Fewest entries a query needs.
  localparam int unsigned MinEntries = 2;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } wis_func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_OVF  = 2'd3
  } wis_status_e;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_PROBE,
    SRCH_FINAL
  } wis_srch_state_e;

  typedef struct packed {
    wis_func_e   func;
    logic [15:0] weight;
    logic [31:0] target;
  } wis_in_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] total;
    logic [8:0]  entries;
    wis_status_e status;
  } wis_out_t;

endpackage

/* rtl/weighted_index_selector.sv */
// ----------------------------------------------------------------------------
// weighted_index_selector
// Weighted selection by inverse cumulative distribution over a RAM table.
// ----------------------------------------------------------------------------
// Clear, append and a query on fewer than two entries give their result on
//   done_o in the cycle after the accepting edge.
// A query on n >= 2 entries goes to the search unit: one RAM probe per cycle
//   through the table's read port, then a final compare picks the index.
// busy is high while a query searches; the next item is taken the cycle it
//   drops. Results cannot be stalled. Reset empties the table (no RAM sweep).
module weighted_index_selector #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned SUM_WIDTH     = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wis_pkg::wis_in_t  item_i,
  output logic              done_o,
  output wis_pkg::wis_out_t result_o
);

  import wis_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW    = ((SUM_WIDTH > 16) ? SUM_WIDTH : 16) + 1;

  // Architectural state: fill count and running sum; sums live in the RAM.
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SUM_WIDTH-1:0] sum_q, sum_d;

  // Result register.
  logic                 done_q, done_d;
  wis_out_t             res_q, res_d;

  logic                 accept;
  logic                 full, few, ovf;
  logic [EW-1:0]        sum_ext;
  logic [CNT_W-1:0]     cnt_m1;
  logic                 wr_en;

  // Search unit hookup.
  logic                 srch_go, srch_busy, srch_done, rd_en;
  logic [AW-1:0]        rd_addr, srch_index;
  logic [SUM_WIDTH-1:0] rd_data;

  // Zero-padded copies so that any parameter value maps onto the fixed fields.
  logic [CNT_W+8:0]     ent_pad;
  logic [SUM_WIDTH+31:0] tot_pad;
  logic [AW+7:0]        idx_pad;

  assign accept  = start && !busy;
  assign busy    = srch_busy;

  assign full    = count_q >= CNT_W'(TABLE_ENTRIES);
  assign few     = count_q < CNT_W'(MinEntries);
  assign sum_ext = EW'(sum_q) + EW'(item_i.weight);
  assign ovf     = |sum_ext[EW-1:SUM_WIDTH];
  assign cnt_m1  = count_q - CNT_W'(1);
  assign idx_pad = {8'd0, srch_index};

  assign srch_go = accept && (item_i.func == FUNC_QUERY) && !few;
  assign wr_en   = accept && (item_i.func == FUNC_APPEND) && !full && !ovf;

  wis_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (sum_ext[SUM_WIDTH-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  wis_search #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (srch_go),
    .last_i    (cnt_m1[AW-1:0]),
    .target_i  (item_i.target),
    .rdata_i   (rd_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .busy_o    (srch_busy),
    .done_o    (srch_done),
    .index_o   (srch_index)
  );

  // Item decode: state update plus the result for items that finish at once.
  always_comb begin
    count_d        = count_q;
    sum_d          = sum_q;
    done_d         = 1'b0;
    res_d.index    = '0;
    res_d.status   = ST_OK;
    if (accept) begin
      done_d = 1'b1;
      unique case (item_i.func)
        FUNC_CLEAR: begin
          count_d = '0;
          sum_d   = '0;
        end
        FUNC_APPEND: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else if (ovf) begin
            res_d.status = ST_OVF;
          end else begin
            sum_d   = sum_ext[SUM_WIDTH-1:0];
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_QUERY: begin
          // Result comes from the search unit unless the table is too short.
          if (few) begin
            res_d.status = ST_FEW;
          end else begin
            done_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (srch_done) begin
      done_d      = 1'b1;
      res_d.index = idx_pad[7:0];
    end
    ent_pad       = {9'd0, count_d};
    tot_pad       = {32'd0, sum_d};
    res_d.entries = ent_pad[8:0];
    res_d.total   = tot_pad[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------

  // A result never shows while a search still runs.
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_o && busy))
    else $error("result strobe while search busy");

  // Items other than a real search answer in the next cycle.
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !srch_go) |=> done_o)
    else $error("missing one-cycle result");

  // A started search holds its result back and keeps the block busy.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_go |=> (busy && !done_o))
    else $error("search did not hold off");

  // Fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

endmodule

/* rtl/wis_ram.sv */
// ----------------------------------------------------------------------------
// wis_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module wis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/wis_search.sv */
// ----------------------------------------------------------------------------
// wis_search
// Binary search over the cumulative table, one probe per cycle.
// ----------------------------------------------------------------------------
module wis_search #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned SUM_WIDTH     = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             go_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] last_i,
  input  logic [31:0]                      target_i,
  input  logic [SUM_WIDTH-1:0]             rdata_i,
  output logic                             rd_en_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_o,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] index_o
);

  import wis_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;

  wis_srch_state_e state_q, state_d;
  logic [AW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0]     tgt_q, tgt_d;

  logic [CW-1:0]   ent_x, tgt_x;
  logic            lt;
  logic [AW-1:0]   lo_n, hi_n, span, mid_n;
  logic            more;

  assign ent_x = CW'(rdata_i);
  assign tgt_x = CW'(tgt_q);
  assign lt    = ent_x < tgt_x;

  // Narrow the pair from the probe that just came back.
  assign lo_n  = lt ? mid_q : lo_q;
  assign hi_n  = lt ? hi_q : mid_q;
  assign span  = hi_n - lo_n;
  assign mid_n = lo_n + (span >> 1);
  assign more  = ({1'b0, lo_n} + {{AW{1'b0}}, 1'b1}) < {1'b0, hi_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SRCH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    tgt_q <= tgt_d;
  end

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    tgt_d     = tgt_q;
    rd_en_o   = 1'b0;
    rd_addr_o = lo_q;
    done_o    = 1'b0;
    index_o   = lo_q;
    unique case (state_q)
      SRCH_IDLE: begin
        if (go_i) begin
          tgt_d   = target_i;
          lo_d    = '0;
          hi_d    = last_i;
          rd_en_o = 1'b1;
          if (last_i > AW'(1)) begin
            mid_d     = last_i >> 1;
            rd_addr_o = last_i >> 1;
            state_d   = SRCH_PROBE;
          end else begin
            rd_addr_o = '0;
            state_d   = SRCH_FINAL;
          end
        end
      end
      SRCH_PROBE: begin
        lo_d    = lo_n;
        hi_d    = hi_n;
        rd_en_o = 1'b1;
        if (more) begin
          mid_d     = mid_n;
          rd_addr_o = mid_n;
        end else begin
          rd_addr_o = lo_n;
          state_d   = SRCH_FINAL;
        end
      end
      SRCH_FINAL: begin
        // rdata holds entry lo
        done_o  = 1'b1;
        index_o = (tgt_x <= ent_x) ? lo_q : hi_q;
        state_d = SRCH_IDLE;
      end
      default: begin
        state_d = SRCH_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != SRCH_IDLE);

endmodule
